// ===== hdl/atsd_pkg.sv =====
// Shared constants and types of the adaptive-threshold step detector.
// No dependencies; imported by the channel interfaces, the detector top and the testbench.
`default_nettype none

package atsd_pkg;

  // Fixed field widths.
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 32;
  localparam int LEVEL_OUT_W = 16;

  // Configuration port and register widths.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int WIN_LEN_W   = 6;
  localparam int THR_W       = 16;
  localparam int HYST_W      = 12;
  localparam int INTERVAL_W  = 16;
  localparam int WEIGHT_W    = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_LEN        = 3'd0,
    REG_THRESHOLD_FLOOR   = 3'd1,
    REG_INITIAL_THRESHOLD = 3'd2,
    REG_HYSTERESIS        = 3'd3,
    REG_MIN_INTERVAL_MS   = 3'd4,
    REG_FILTER_WEIGHT     = 3'd5
  } cfg_reg_t;

  // Register reset values.
  localparam logic [WIN_LEN_W-1:0]  WINDOW_LEN_RESET   = 6'd50;
  localparam logic [THR_W-1:0]      FLOOR_RESET        = 16'd2212;
  localparam logic [THR_W-1:0]      INIT_THR_RESET     = 16'd2294;
  localparam logic [HYST_W-1:0]     HYST_RESET         = 12'd102;
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 16'd250;
  localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET       = 8'd38;

  // Level constants, integer part (1 LSB = 1/2048 g).
  localparam logic [12:0] LEVEL_ONE_G = 13'd2048;
  localparam logic [12:0] LEVEL_TWO_G = 13'd4096;

  // Unity weight of the low-pass filter.
  localparam logic [WEIGHT_W:0] FILTER_UNITY = 9'd256;

endpackage

`default_nettype wire

// ===== hdl/atsd_if.sv =====
// Valid/ready channels of the step detector: sample in, result out, config write.
// Depends on atsd_pkg.
`default_nettype none

interface atsd_sample_if #(
  parameter int ACCEL_BITS = 16
);
  import atsd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [ACCEL_BITS-1:0] accel_x;
  logic signed [ACCEL_BITS-1:0] accel_y;
  logic signed [ACCEL_BITS-1:0] accel_z;
  logic [TIME_W-1:0]            now_ms;

  modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface atsd_result_if;
  import atsd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COUNT_W-1:0]     step_total;
  logic                   step_seen;
  logic [LEVEL_OUT_W-1:0] filtered_level;
  logic [LEVEL_OUT_W-1:0] current_threshold;

  modport source (output valid, step_total, step_seen, filtered_level, current_threshold,
                  input ready);
  modport sink   (input valid, step_total, step_seen, filtered_level, current_threshold,
                  output ready);
endinterface

interface atsd_cfg_if;
  import atsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/atsd_isqrt.sv =====
// Bit-serial floor square root, one root bit per cycle (restoring method).
// Standalone; used by adaptive_threshold_step_detector_top.
`default_nettype none

module atsd_isqrt #(
  parameter int ROOT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic                busy;
  logic [CNT_W-1:0]    steps;
  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W:0]     rem;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic [ROOT_W+1:0]   diff;
  logic                fits;

  // Bring down the next two radicand bits, try 4*root+1.
  assign rem_sh = {rem[ROOT_W-1:0], rad[2*ROOT_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (steps == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(ROOT_W);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/adaptive_threshold_step_detector_top.sv =====
// Adaptive-threshold step detector. One sample request (three signed axes plus a
// millisecond timestamp) goes in, one result request comes out: the running step
// count, whether this sample counted a step, and the integer parts of the filtered
// magnitude and of the threshold in use. The block works on one sample at a time:
// no new sample is taken until the current one has passed every sequencer state,
// with most of the time spent in the bit-serial square root of the squares, which
// yields one root bit per cycle. The three squares and the two filter products all
// go through one shared multiplier, one product per cycle. The result sits in an
// output register, so a new sample is accepted while the last result still waits;
// the sequencer only stalls at its final step if the previous result is still
// unclaimed. Configuration writes are always ready and meant for idle periods;
// writing initial_threshold also reloads the live threshold.
// Depends on atsd_pkg, atsd_if (channel interfaces) and atsd_isqrt.
`default_nettype none

module adaptive_threshold_step_detector_top #(
  parameter int ACCEL_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  atsd_sample_if.sink          sample,
  atsd_result_if.source        result,
  atsd_cfg_if.sink             cfg
);
  import atsd_pkg::*;

  // Level width: integer part covers the root and the 16-bit thresholds.
  localparam int LVL_W = ((ACCEL_BITS > THR_W) ? ACCEL_BITS : THR_W) + FRACTION_BITS;
  localparam int MB_W  = (ACCEL_BITS > WEIGHT_W + 1) ? ACCEL_BITS : WEIGHT_W + 1;
  localparam int SQ_W  = 2 * ACCEL_BITS;
  localparam int ACC_W = (SQ_W > LVL_W + WEIGHT_W) ? SQ_W : LVL_W + WEIGHT_W;
  localparam int MUL_W = LVL_W + MB_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,  // three squares, accumulated
    S_SQRT = 7'b0000100,  // wait for root
    S_FILT = 7'b0001000,  // two weighted products, then sum
    S_WIN  = 7'b0010000,  // window min/max/count
    S_MID  = 7'b0100000,  // threshold recompute at window end
    S_DET  = 7'b1000000   // crossing detect, result load
  } state_t;

  state_t state;
  logic [1:0] phase;

  // Captured sample.
  logic signed [ACCEL_BITS-1:0] ax, ay, az;
  logic [TIME_W-1:0]            now_q;

  // Configuration registers. initial_threshold only acts at its write, where it
  // loads the live threshold, so it needs no register of its own.
  logic [WIN_LEN_W-1:0]  win_len;
  logic [THR_W-1:0]      thr_floor;
  logic [HYST_W-1:0]     hyst;
  logic [INTERVAL_W-1:0] min_int;
  logic [WEIGHT_W-1:0]   fweight;

  // Detector state.
  logic [LVL_W-1:0]     filt;
  logic [LVL_W-1:0]     threshold;
  logic [LVL_W-1:0]     wlow;
  logic [LVL_W-1:0]     whigh;
  logic [WIN_LEN_W-1:0] wcount;
  logic                 win_due;
  logic                 armed;
  logic [TIME_W-1:0]    last_step;
  logic [COUNT_W-1:0]   step_count;

  // Shared multiplier and accumulator.
  logic [LVL_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MUL_W-1:0] mul_full;
  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_sum;

  logic signed [ACCEL_BITS-1:0] axis_sel;
  logic [ACCEL_BITS-1:0]        axis_abs;

  logic                  sq_start;
  logic                  sq_done;
  logic [ACCEL_BITS-1:0] root;
  logic [LVL_W-1:0]      mag;
  logic [LVL_W-1:0]      filt_new;

  logic [WIN_LEN_W-1:0] wcount_next;
  logic [LVL_W-1:0]     wlow_next;
  logic [LVL_W-1:0]     whigh_next;
  logic [LVL_W:0]       mid_sum;
  logic [LVL_W-1:0]     mid;
  logic [LVL_W-1:0]     floor_lvl;

  logic [LVL_W:0]       hyst_up;
  logic                 rise;
  logic                 rearm;
  logic [TIME_W-1:0]    elapsed;
  logic                 step_hit;
  logic [COUNT_W-1:0]   step_count_next;

  logic out_valid;
  logic out_free;

  logic sample_take;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign sample.ready = (state == S_IDLE);
  assign sample_take  = sample.valid && sample.ready;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign out_free     = !out_valid || result.ready;

  // ---------------------------------------------------------------------------
  // Shared multiplier: axis squares, then w*mag and (256-w)*filtered
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (phase)
      2'd0:    axis_sel = ax;
      2'd1:    axis_sel = ay;
      default: axis_sel = az;
    endcase
  end

  // Magnitude of the axis; the most negative code maps to 2^(ACCEL_BITS-1).
  assign axis_abs = axis_sel[ACCEL_BITS-1] ? ACCEL_BITS'(-axis_sel) : ACCEL_BITS'(axis_sel);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ) begin
      mul_a = LVL_W'(axis_abs);
      mul_b = MB_W'(axis_abs);
    end else if (state == S_FILT) begin
      if (phase == 2'd0) begin
        mul_a = mag;
        mul_b = MB_W'(fweight);
      end else begin
        mul_a = filt;
        mul_b = MB_W'(FILTER_UNITY - {1'b0, fweight});
      end
    end
  end

  assign mul_full = mul_a * mul_b;
  assign acc_sum  = acc + prod;

  // Square root of the sum of squares.
  assign sq_start = (state == S_SQ) && (phase == 2'd3);

  atsd_isqrt #(
    .ROOT_W (ACCEL_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc_sum[SQ_W-1:0]),
    .done     (sq_done),
    .root     (root)
  );

  assign mag      = LVL_W'(root) << FRACTION_BITS;
  assign filt_new = acc_sum[LVL_W+WEIGHT_W-1:WEIGHT_W];

  // ---------------------------------------------------------------------------
  // Window and threshold
  // ---------------------------------------------------------------------------
  assign wcount_next = wcount + WIN_LEN_W'(1);
  assign wlow_next   = (filt < wlow)  ? filt : wlow;
  assign whigh_next  = (filt > whigh) ? filt : whigh;
  assign mid_sum     = {1'b0, wlow} + {1'b0, whigh};
  assign mid         = mid_sum[LVL_W:1];
  assign floor_lvl   = LVL_W'(thr_floor) << FRACTION_BITS;

  // ---------------------------------------------------------------------------
  // Crossing detection
  // ---------------------------------------------------------------------------
  // filt < threshold - hysteresis, rewritten without a negative range.
  assign hyst_up  = {1'b0, filt} + ((LVL_W + 1)'(hyst) << FRACTION_BITS);
  assign rearm    = hyst_up < {1'b0, threshold};
  assign rise     = !armed && (filt > threshold);
  assign elapsed  = now_q - last_step;
  assign step_hit = rise && (elapsed > TIME_W'(min_int));
  assign step_count_next = step_count + COUNT_W'(step_hit);

  // ---------------------------------------------------------------------------
  // Sequencer and state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= '0;
      out_valid  <= 1'b0;
      win_len    <= WINDOW_LEN_RESET;
      thr_floor  <= FLOOR_RESET;
      hyst       <= HYST_RESET;
      min_int    <= MIN_INTERVAL_RESET;
      fweight    <= WEIGHT_RESET;
      filt       <= LVL_W'(LEVEL_ONE_G) << FRACTION_BITS;
      threshold  <= LVL_W'(INIT_THR_RESET) << FRACTION_BITS;
      wlow       <= LVL_W'(LEVEL_TWO_G) << FRACTION_BITS;
      whigh      <= '0;
      wcount     <= '0;
      win_due    <= 1'b0;
      armed      <= 1'b0;
      last_step  <= '0;
      step_count <= '0;
    end else begin
      // A new result fills the output register; otherwise a claimed one leaves it.
      if ((state == S_DET) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample_take) begin
            state <= S_SQ;
            phase <= 2'd0;
          end
        end
        S_SQ: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            state <= S_FILT;
            phase <= 2'd0;
          end
        end
        S_FILT: begin
          phase <= phase + 2'd1;
          if (phase == 2'd2) begin
            filt  <= filt_new;
            state <= S_WIN;
          end
        end
        S_WIN: begin
          wlow    <= wlow_next;
          whigh   <= whigh_next;
          wcount  <= wcount_next;
          win_due <= wcount_next >= win_len;  // zero length: every sample
          state   <= S_MID;
        end
        S_MID: begin
          if (win_due) begin
            threshold <= (mid > floor_lvl) ? mid : floor_lvl;
            wlow      <= LVL_W'(LEVEL_TWO_G) << FRACTION_BITS;
            whigh     <= '0;
            wcount    <= '0;
          end
          state <= S_DET;
        end
        S_DET: begin
          if (out_free) begin
            if (rise) begin
              armed <= 1'b1;
            end else if (rearm) begin
              armed <= 1'b0;
            end
            if (step_hit) begin
              last_step <= now_q;
            end
            step_count <= step_count_next;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Register writes; initial threshold loads the live threshold.
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.addr))
          REG_WINDOW_LEN:        win_len <= cfg.data[WIN_LEN_W-1:0];
          REG_THRESHOLD_FLOOR:   thr_floor <= cfg.data[THR_W-1:0];
          REG_INITIAL_THRESHOLD: begin
            threshold <= LVL_W'(cfg.data[THR_W-1:0]) << FRACTION_BITS;
          end
          REG_HYSTERESIS:        hyst <= cfg.data[HYST_W-1:0];
          REG_MIN_INTERVAL_MS:   min_int <= cfg.data[INTERVAL_W-1:0];
          REG_FILTER_WEIGHT:     fweight <= cfg.data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers: sample capture, product and accumulator.
  always_ff @(posedge clk) begin
    if (sample_take) begin
      ax    <= sample.accel_x;
      ay    <= sample.accel_y;
      az    <= sample.accel_z;
      now_q <= sample.now_ms;
      prod  <= '0;
      acc   <= '0;
    end else if (state == S_SQ) begin
      prod <= mul_full[ACC_W-1:0];
      acc  <= acc_sum;
    end else if (state == S_FILT) begin
      prod <= mul_full[ACC_W-1:0];
      acc  <= prod;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if ((state == S_DET) && out_free) begin
      result.step_total        <= step_count_next;
      result.step_seen         <= step_hit;
      result.filtered_level    <= filt[FRACTION_BITS +: LEVEL_OUT_W];
      result.current_threshold <= threshold[FRACTION_BITS +: LEVEL_OUT_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_SQRT)
    else $error("square root finished outside its wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == S_SQ && phase == 2'd0)
    else $error("accepted sample did not start the square sequence");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && step_count != $past(step_count)
      |-> step_count == $past(step_count) + COUNT_W'(1) && $past(state) == S_DET)
    else $error("step count moved by other than one step at the decision");

  a_floor_held: assert property (@(posedge clk) disable iff (rst)
    state == S_MID && win_due |=> threshold >= floor_lvl)
    else $error("recomputed threshold below floor");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DET && out_free |=> out_valid && state == S_IDLE)
    else $error("decision did not load a result");

endmodule

`default_nettype wire

// ===== test/adaptive_threshold_step_detector_top_tb.sv =====
// Self-checking testbench of adaptive_threshold_step_detector_top: a directed table
// and then random walking-like sample phases, checked against a local step predictor.
// Depends on atsd_pkg, the atsd_if channel interfaces and the detector RTL.

module adaptive_threshold_step_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atsd_pkg::*;

  // Fixed-point fraction of the internal levels.
  localparam int LEVEL_FRAC     = 8;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 152;
  // Idle limit: far above one sample, the longest source gap, the longest sink
  // stall and the one long sink hold-off together.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 500;
  localparam int SETTLE_CYCLES  = 60;

  // Register indexes past the end of the map; writes there must be dropped.
  localparam logic [CFG_ADDR_W-1:0] REG_NONE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_NONE_7 = 3'd7;

  // Value choice for a register write in a random phase.
  typedef enum int {PICK_TYPICAL, PICK_LOW, PICK_HIGH, PICK_RESET} pick_t;

  typedef struct packed {
    logic [15:0]       ax;
    logic [15:0]       ay;
    logic [15:0]       az;
    logic [TIME_W-1:0] now;
  } accel_sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0]     total;
    logic                   seen;
    logic [LEVEL_OUT_W-1:0] level;
    logic [LEVEL_OUT_W-1:0] thr;
  } step_report_t;

  // One row of the directed table: a register write or a sample, the latter
  // optionally carrying a hand-written expected result.
  typedef struct {
    bit                    is_write;
    logic [CFG_ADDR_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0] wdata;
    accel_sample_t         smp;
    bit                    typed;
    step_report_t          want;
  } directed_row_t;

  logic clk;
  logic rst;

  atsd_sample_if #(.ACCEL_BITS(16)) sample_bus ();
  atsd_result_if                    result_bus ();
  atsd_cfg_if                       cfg_bus ();

  adaptive_threshold_step_detector_top #(
    .ACCEL_BITS   (16),
    .FRACTION_BITS(LEVEL_FRAC)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_bus),
    .result(result_bus),
    .cfg   (cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // Step predictor: register copies and detector state, all at block widths.
  // ---------------------------------------------------------------------------
  logic [WIN_LEN_W-1:0]  cfg_win_len;
  logic [THR_W-1:0]      cfg_floor;
  logic [HYST_W-1:0]     cfg_hyst;
  logic [INTERVAL_W-1:0] cfg_interval;
  logic [WEIGHT_W-1:0]   cfg_weight;

  logic [23:0]          lvl_q;       // filtered magnitude, 8 fraction bits
  logic [23:0]          thr_q;       // threshold in use
  logic [23:0]          win_lo;
  logic [23:0]          win_hi;
  logic [5:0]           win_cnt;
  logic                 armed;
  logic [TIME_W-1:0]    last_step;
  logic [COUNT_W-1:0]   steps;

  // Expected reports, oldest first.
  step_report_t  pending_reports[$];
  directed_row_t directed_rows[$];

  // Driver-side tags that travel with each sample request.
  logic         row_typed;
  step_report_t row_want;

  logic hold_req;      // one long sink hold-off
  logic sink_idle;     // sink may stall in this phase
  bit   src_idle;      // source may insert gaps in this phase

  int samples_taken;
  int directed_count;
  int writes_done;
  int steps_flagged;
  int reports_checked;
  int fails;

  function automatic void window_restart();
    win_lo  = 24'(LEVEL_TWO_G) << LEVEL_FRAC;
    win_hi  = '0;
    win_cnt = '0;
  endfunction

  function automatic void predictor_reset();
    cfg_win_len  = WINDOW_LEN_RESET;
    cfg_floor    = FLOOR_RESET;
    cfg_hyst     = HYST_RESET;
    cfg_interval = MIN_INTERVAL_RESET;
    cfg_weight   = WEIGHT_RESET;
    lvl_q        = 24'(LEVEL_ONE_G) << LEVEL_FRAC;
    thr_q        = 24'(INIT_THR_RESET) << LEVEL_FRAC;
    window_restart();
    armed        = 1'b0;
    last_step    = '0;
    steps        = '0;
  endfunction

  function automatic void load_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_WINDOW_LEN:      cfg_win_len  = d[WIN_LEN_W-1:0];
      REG_THRESHOLD_FLOOR: cfg_floor    = d[THR_W-1:0];
      REG_INITIAL_THRESHOLD: begin
        // the live threshold follows right away
        thr_q = 24'(d[THR_W-1:0]) << LEVEL_FRAC;
      end
      REG_HYSTERESIS:      cfg_hyst     = d[HYST_W-1:0];
      REG_MIN_INTERVAL_MS: cfg_interval = d[INTERVAL_W-1:0];
      REG_FILTER_WEIGHT:   cfg_weight   = d[WEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  // Digit-by-digit floor square root; the root of three full-scale squares
  // stays below 2^16.
  function automatic logic [15:0] floor_sqrt(longint unsigned n);
    logic [15:0]     root;
    longint unsigned trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (trial * trial <= n) begin
        root = 16'(trial);
      end
    end
    return root;
  endfunction

  function automatic step_report_t detect_step(accel_sample_t s);
    longint          sx, sy, sz, low_mark;
    longint unsigned energy, mag, w, mid, fl;
    logic [TIME_W-1:0] elapsed;
    step_report_t    r;
    sx     = longint'($signed(s.ax));
    sy     = longint'($signed(s.ay));
    sz     = longint'($signed(s.az));
    energy = sx * sx + sy * sy + sz * sz;
    mag    = longint'(floor_sqrt(energy)) << LEVEL_FRAC;
    w      = cfg_weight;
    lvl_q  = 24'((w * mag + (256 - w) * lvl_q) >> 8);

    if (lvl_q < win_lo) win_lo = lvl_q;
    if (lvl_q > win_hi) win_hi = lvl_q;
    win_cnt = win_cnt + 1'b1;
    // window length zero recomputes on every sample
    if (win_cnt >= cfg_win_len) begin
      mid   = (longint'(win_lo) + win_hi) >> 1;
      fl    = longint'(cfg_floor) << LEVEL_FRAC;
      thr_q = 24'(mid > fl ? mid : fl);
      window_restart();
    end

    // low mark may go negative, so compare signed
    low_mark = longint'(thr_q) - (longint'(cfg_hyst) << LEVEL_FRAC);
    r.seen   = 1'b0;
    if (!armed && lvl_q > thr_q) begin
      elapsed = s.now - last_step;
      if (elapsed > cfg_interval) begin
        steps     = steps + 1'b1;
        last_step = s.now;
        r.seen    = 1'b1;
      end
      armed = 1'b1;
    end else if (longint'(lvl_q) < low_mark) begin
      armed = 1'b0;
    end

    r.total = steps;
    r.level = LEVEL_OUT_W'(lvl_q >> LEVEL_FRAC);
    r.thr   = LEVEL_OUT_W'(thr_q >> LEVEL_FRAC);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and idle-length choice.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int unsigned gap_cycles();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: every register write updates the predictor's register copies, every
  // accepted sample is run through the predictor, and every result request is checked
  // field by field against the oldest expectation.
  always @(posedge clk) begin : monitor
    step_report_t calc;
    step_report_t want;
    if (!rst && cfg_bus.valid && cfg_bus.ready) begin
      load_register(cfg_bus.addr, cfg_bus.data);
      writes_done++;
    end
    if (!rst && sample_bus.valid && sample_bus.ready) begin
      calc = detect_step({sample_bus.accel_x, sample_bus.accel_y, sample_bus.accel_z,
                          sample_bus.now_ms});
      // table rows with a hand-written answer override the predictor
      pending_reports.push_back(row_typed ? row_want : calc);
      samples_taken++;
    end
    if (!rst && result_bus.valid && result_bus.ready) begin
      reports_checked++;
      if (result_bus.step_seen === 1'b1) steps_flagged++;
      if (pending_reports.size() == 0) begin
        $error("result request with no sample pending (step_total %0d)",
               result_bus.step_total);
        fails++;
      end else begin
        want = pending_reports.pop_front();
        if (result_bus.step_total !== want.total) begin
          $error("step_total: expected %0d, got %0d", want.total, result_bus.step_total);
          fails++;
        end
        if (result_bus.step_seen !== want.seen) begin
          $error("step_seen: expected %0d, got %0d", want.seen, result_bus.step_seen);
          fails++;
        end
        if (result_bus.filtered_level !== want.level) begin
          $error("filtered_level: expected %0d, got %0d", want.level,
                 result_bus.filtered_level);
          fails++;
        end
        if (result_bus.current_threshold !== want.thr) begin
          $error("current_threshold: expected %0d, got %0d", want.thr,
                 result_bus.current_threshold);
          fails++;
        end
      end
    end
  end

  // Watchdog: any stretch without a single handshake on any channel is a hang.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL adaptive_threshold_step_detector_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off counted here so that the
  // block's output register fills and it stops taking sample requests.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  bit          hold_done;
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done        = 1'b1;
      stall_left       = LONG_HOLD;
      result_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
      if (sink_idle && $urandom_range(3) == 0) stall_left = gap_cycles();
    end
  end

  // ---------------------------------------------------------------------------
  // Source side.
  // ---------------------------------------------------------------------------
  // Valid stays high between back-to-back requests; at most one NBA per step.
  task automatic offer_sample(accel_sample_t s, bit typed, step_report_t want);
    int unsigned pause;
    pause = src_idle ? gap_cycles() : 0;
    if (pause != 0) begin
      sample_bus.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    sample_bus.valid   <= 1'b1;
    sample_bus.accel_x <= s.ax;
    sample_bus.accel_y <= s.ay;
    sample_bus.accel_z <= s.az;
    sample_bus.now_ms  <= s.now;
    row_typed          <= typed;
    row_want           <= want;
    do @(posedge clk); while (sample_bus.ready !== 1'b1);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    directed_row_t row;
    row           = '{default: '0};
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.wdata     = d;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(int x, int y, int z, logic [TIME_W-1:0] ms,
                                     bit typed = 0, int total = 0, bit seen = 0,
                                     int lvl = 0, int thr = 0);
    directed_row_t row;
    row            = '{default: '0};
    row.smp        = {16'(x), 16'(y), 16'(z), ms};
    row.typed      = typed;
    row.want.total = COUNT_W'(total);
    row.want.seen  = seen;
    row.want.level = LEVEL_OUT_W'(lvl);
    row.want.thr   = LEVEL_OUT_W'(thr);
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    accel_sample_t         s;
    cfg_reg_t              reg_id;
    pick_t                 pick;
    logic [CFG_DATA_W-1:0] value;
    int                    width;
    int                    period, amp, dt, grav_axis, pos, wave, g, side1, side2;
    bit                    grav_neg;
    logic [TIME_W-1:0]     clock_ms;

    rst                = 1'b1;
    sample_bus.valid   = 1'b0;
    sample_bus.accel_x = '0;
    sample_bus.accel_y = '0;
    sample_bus.accel_z = '0;
    sample_bus.now_ms  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.addr       = '0;
    cfg_bus.data       = '0;
    row_typed          = 1'b0;
    row_want           = '0;
    hold_req           = 1'b0;
    sink_idle          = 1'b1;
    src_idle           = 1'b1;
    predictor_reset();

    // Directed table. With filter weight zero the level is pinned at 1.0 g,
    // so thresholds and step decisions can be written down by hand.
    add_write(REG_FILTER_WEIGHT, 16'd0);
    add_sample(-32768, -32768, -32768, 32'd0, 1, 0, 0, 2048, 2294);
    add_sample(32767, 32767, 32767, 32'hFFFF_FFFF, 1, 0, 0, 2048, 2294);
    add_write(REG_MIN_INTERVAL_MS, 16'd0);
    add_write(REG_INITIAL_THRESHOLD, 16'd0);          // loads the threshold too
    add_sample(0, 0, 0, 32'd1, 1, 1, 1, 2048, 0);     // rising crossing counts
    add_sample(0, 0, 0, 32'd2, 1, 1, 0, 2048, 0);     // still armed
    add_write(REG_INITIAL_THRESHOLD, 16'hFFFF);
    add_sample(-1, 1, -1, 32'd3, 1, 1, 0, 2048, 65535); // far below: re-arm
    add_write(REG_HYSTERESIS, 16'd0);
    add_write(REG_INITIAL_THRESHOLD, 16'd2047);
    add_sample(5, 5, 5, 32'd1, 1, 1, 0, 2048, 2047);  // elapsed equals interval
    add_write(REG_INITIAL_THRESHOLD, 16'd2049);
    add_sample(5, 5, 5, 32'd5, 1, 1, 0, 2048, 2049);  // just below, zero margin
    add_write(REG_INITIAL_THRESHOLD, 16'd2047);
    add_sample(7, 7, 7, 32'd0, 1, 2, 1, 2048, 2047);  // elapsed time wraps
    add_write(REG_THRESHOLD_FLOOR, 16'd0);
    add_write(REG_WINDOW_LEN, 16'd1);
    add_sample(9, 9, 9, 32'd10, 1, 2, 0, 2048, 2048); // window midpoint wins
    add_write(REG_THRESHOLD_FLOOR, 16'hFFFF);
    add_sample(9, 9, 9, 32'd20, 1, 2, 0, 2048, 65535); // floor wins
    add_write(REG_WINDOW_LEN, 16'h0040);              // masks to zero length
    add_write(REG_THRESHOLD_FLOOR, 16'd3000);
    add_sample(9, 9, 9, 32'd30, 1, 2, 0, 2048, 3000);
    add_write(REG_NONE_6, 16'hFFFF);                  // unmapped, ignored
    add_write(REG_NONE_7, 16'h0001);
    add_sample(9, 9, 9, 32'd40, 1, 2, 0, 2048, 3000);
    // live filter from here on, checked by the predictor
    add_write(REG_FILTER_WEIGHT, 16'd255);
    add_write(REG_WINDOW_LEN, 16'h003F);
    add_write(REG_THRESHOLD_FLOOR, 16'd0);
    add_write(REG_HYSTERESIS, 16'hFFFF);
    add_write(REG_MIN_INTERVAL_MS, 16'hFFFF);
    add_write(REG_INITIAL_THRESHOLD, 16'd2000);
    add_sample(32767, 32767, 32767, 32'd100);
    add_sample(-32768, 0, 0, 32'd200);
    add_sample(0, -32768, 0, 32'd300);
    add_sample(0, 0, 32767, 32'd400);
    add_sample(1, -1, 1, 32'd500);
    add_write(REG_FILTER_WEIGHT, 16'd1);
    add_write(REG_MIN_INTERVAL_MS, 16'd0);
    add_write(REG_HYSTERESIS, 16'd0);
    add_write(REG_WINDOW_LEN, 16'd3);
    add_sample(32767, -32768, 32767, 32'h8000_0000);
    add_sample(0, 0, 0, 32'h8000_0001);
    add_sample(12345, -23456, 2048, 32'h7FFF_FFFF);
    add_sample(-2048, 0, 0, 32'hFFFF_FFFE);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain();
        write_register(directed_rows[i].reg_index, directed_rows[i].wdata);
      end else begin
        offer_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
        directed_count++;
      end
    end

    // Random phases: each starts idle, reprograms the detector (defaults first,
    // then all maxima, then minima, then mixed picks) and plays a walking-like
    // wave along one gravity axis, sprinkled with full-range noise requests.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      reg_id = reg_id.first();
      repeat (reg_id.num()) begin
        if (ph <= 2 || $urandom_range(9) < 6) begin
          if (ph == 0)                    pick = PICK_RESET;
          else if (ph == 1)               pick = PICK_HIGH;
          else if (ph == 2)               pick = PICK_LOW;
          else if ($urandom_range(9) < 2) pick = $urandom_range(1) ? PICK_HIGH : PICK_LOW;
          else                            pick = PICK_TYPICAL;
          case (reg_id)
            REG_WINDOW_LEN: begin
              width = WIN_LEN_W;
              value = pick == PICK_RESET ? 16'(WINDOW_LEN_RESET) :
                      pick == PICK_LOW   ? 16'($urandom_range(1)) :
                      pick == PICK_HIGH  ? 16'd63 : 16'($urandom_range(60, 4));
            end
            REG_THRESHOLD_FLOOR: begin
              width = THR_W;
              value = pick == PICK_RESET ? 16'(FLOOR_RESET) :
                      pick == PICK_LOW   ? 16'd0 :
                      pick == PICK_HIGH  ? 16'hFFFF : 16'($urandom_range(2400, 1500));
            end
            REG_INITIAL_THRESHOLD: begin
              width = THR_W;
              value = pick == PICK_RESET ? 16'(INIT_THR_RESET) :
                      pick == PICK_LOW   ? 16'd0 :
                      pick == PICK_HIGH  ? 16'hFFFF : 16'($urandom_range(2600, 1800));
            end
            REG_HYSTERESIS: begin
              width = HYST_W;
              value = pick == PICK_RESET ? 16'(HYST_RESET) :
                      pick == PICK_LOW   ? 16'd0 :
                      pick == PICK_HIGH  ? 16'd4095 : 16'($urandom_range(300, 0));
            end
            REG_MIN_INTERVAL_MS: begin
              width = INTERVAL_W;
              value = pick == PICK_RESET ? 16'(MIN_INTERVAL_RESET) :
                      pick == PICK_LOW   ? 16'd0 :
                      pick == PICK_HIGH  ? 16'hFFFF : 16'($urandom_range(500, 0));
            end
            default: begin
              width = WEIGHT_W;
              value = pick == PICK_RESET ? 16'(WEIGHT_RESET) :
                      pick == PICK_LOW   ? 16'($urandom_range(1)) :
                      pick == PICK_HIGH  ? 16'd255 : 16'($urandom_range(120, 16));
            end
          endcase
          // junk above the register width must be masked off by the block
          write_register(reg_id, 16'(value | ($urandom << width)));
        end
        reg_id = reg_id.next();
      end
      if ($urandom_range(4) == 0) begin
        write_register($urandom_range(1) ? REG_NONE_6 : REG_NONE_7, 16'($urandom));
      end

      // some phases run without any idling on one side or the other
      src_idle  = (ph % 3 != 1);
      sink_idle <= (ph % 4 != 2);

      period    = $urandom_range(40, 8);
      amp       = $urandom_range(1500, 150);
      dt        = $urandom_range(40, 5);
      grav_axis = $urandom_range(2);
      grav_neg  = $urandom_range(1);
      // some phases start just short of the timestamp wrap
      clock_ms  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(2000) : $urandom;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(9) == 0) begin
          s.ax  = 16'($urandom);
          s.ay  = 16'($urandom);
          s.az  = 16'($urandom);
          s.now = $urandom_range(1) ? $urandom : clock_ms;
        end else begin
          // triangle wave around 1 g: -amp at the start of a stride, +amp halfway
          pos   = k % period;
          wave  = (pos < period / 2) ? -amp + 4 * amp * pos / period
                                     : 3 * amp - 4 * amp * pos / period;
          g     = 2048 + wave + int'($urandom_range(80)) - 40;
          if (grav_neg) g = -g;
          side1 = int'($urandom_range(400)) - 200;
          side2 = int'($urandom_range(400)) - 200;
          case (grav_axis)
            0:       begin s.ax = 16'(g);     s.ay = 16'(side1); s.az = 16'(side2); end
            1:       begin s.ax = 16'(side1); s.ay = 16'(g);     s.az = 16'(side2); end
            default: begin s.ax = 16'(side1); s.ay = 16'(side2); s.az = 16'(g);     end
          endcase
          clock_ms = clock_ms + dt + $urandom_range(3);
          s.now    = clock_ms;
        end
        offer_sample(s, 1'b0, '0);
        // long sink hold-off while the source keeps offering
        if (ph == 3 && k == 20) hold_req <= 1'b1;
        // source stops mid-phase until all results are back
        if (ph == 6 && k == 70) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d samples (%0d from the directed table), %0d register writes",
             samples_taken, directed_count, writes_done);
    $display("%0d steps flagged, %0d results compared, %0d mismatches",
             steps_flagged, reports_checked, fails);
    if (fails == 0 && pending_reports.size() == 0) begin
      $display("PASS adaptive_threshold_step_detector_top");
    end else begin
      $display("FAIL adaptive_threshold_step_detector_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/atsd_pkg.sv
hdl/atsd_if.sv
hdl/atsd_isqrt.sv
hdl/adaptive_threshold_step_detector_top.sv
test/adaptive_threshold_step_detector_top_tb.sv
